[rtl/core/indexed_list_insert_remove_top_defines.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the indexed list checker
// ---------------------------------------------------------------------------
`ifndef INDEXED_LIST_INSERT_REMOVE_TOP_DEFINES_SVH
`define INDEXED_LIST_INSERT_REMOVE_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high
`define ILIR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high
`define ILIR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/ilir_pkg.sv]
// ---------------------------------------------------------------------------
// ilir_pkg
// Shared sizes, codes and word types of the indexed list.
// ---------------------------------------------------------------------------
package ilir_pkg;

   // storage geometry
   localparam int DEPTH       = 64;
   localparam int ELEM_W      = 32;
   localparam int CNT_W       = 7;
   localparam int CMD_W       = 3;
   localparam int STAT_W      = 2;
   localparam int GROUP_SIZE  = 8;
   localparam int NUM_GROUPS  = DEPTH / GROUP_SIZE;
   localparam int CAP_RESET   = 64;

   // command codes
   localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd1;
   localparam logic [CMD_W-1:0] CMD_GET    = 3'd2;
   localparam logic [CMD_W-1:0] CMD_SET    = 3'd3;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

   // status codes
   localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
   localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd2;
   localparam logic [STAT_W-1:0] ST_BADPOS = 2'd3;

   // what every cell does this cycle
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_REMOVE,
      CELL_WRITE
   } cell_op_type;

   typedef struct packed {
      cell_op_type        op;
      logic [CNT_W-1:0]   pos;
      logic [ELEM_W-1:0]  value;
   } cell_ctrl_type;

   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [CNT_W-1:0]   position;
      logic [ELEM_W-1:0]  elem_value;
   } req_word_type;

   typedef struct packed {
      logic [STAT_W-1:0]  status;
      logic [ELEM_W-1:0]  data_out;
      logic [CNT_W-1:0]   count;
   } rsp_word_type;

endpackage

[rtl/core/ilir_cell.sv]
// ---------------------------------------------------------------------------
// ilir_cell
// One list entry. Shifts up, shifts down, takes a new value or holds, by
// comparing its own rank with the broadcast position.
// ---------------------------------------------------------------------------
module ilir_cell import ilir_pkg::*; (
   input  logic                clock,
   input  cell_ctrl_type       ctrl,
   input  logic [CNT_W-1:0]    cell_idx,
   input  logic [ELEM_W-1:0]   left_entry,
   input  logic [ELEM_W-1:0]   right_entry,
   output logic [ELEM_W-1:0]   entry,
   output logic [ELEM_W-1:0]   sel_data
);

   logic [ELEM_W-1:0] entry_ff;
   logic [ELEM_W-1:0] entry_in;

   // next entry value
   always_comb begin
      entry_in = entry_ff;
      case (ctrl.op)
         CELL_INSERT: begin
            if (cell_idx > ctrl.pos) begin
               entry_in = left_entry;
            end else if (cell_idx == ctrl.pos) begin
               entry_in = ctrl.value;
            end
         end
         CELL_REMOVE: begin
            if (cell_idx >= ctrl.pos) begin
               entry_in = right_entry;
            end
         end
         CELL_WRITE: begin
            if (cell_idx == ctrl.pos) begin
               entry_in = ctrl.value;
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   // payload only, no reset
   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry    = entry_ff;
   // old contents offered to the read tree when addressed
   assign sel_data = (cell_idx == ctrl.pos) ? entry_ff : '0;

endmodule

[rtl/core/ilir_gather.sv]
// ---------------------------------------------------------------------------
// ilir_gather
// Two-level OR tree that picks the addressed entry out of the cell row.
// First level is registered per group of cells.
// ---------------------------------------------------------------------------
module ilir_gather import ilir_pkg::*; (
   input  logic                clock,
   input  logic                load,
   input  logic [ELEM_W-1:0]   sel_data [DEPTH],
   output logic [ELEM_W-1:0]   data_out
);

   logic [ELEM_W-1:0] group_ff [NUM_GROUPS];
   logic [ELEM_W-1:0] group_in [NUM_GROUPS];

   // first level: one OR per group
   always_comb begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
         group_in[g] = '0;
         for (int k = 0; k < GROUP_SIZE; k++) begin
            group_in[g] = group_in[g] | sel_data[g*GROUP_SIZE + k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         group_ff <= group_in;
      end
   end

   // second level: OR across groups
   always_comb begin
      data_out = '0;
      for (int g = 0; g < NUM_GROUPS; g++) begin
         data_out = data_out | group_ff[g];
      end
   end

endmodule

[rtl/core/indexed_list_insert_remove_top.sv]
// A req word passes the s1 stage and then the result register before
// rsp_valid rises. Throughput: one word per cycle while rsp_stall is low.
// Cells shift or write at the accept edge; the read goes through a
// two-level OR tree whose first level is registered.
// Reset (synchronous, active high): count to zero, capacity_limit to 64,
// pipeline and result valids cleared; cell contents are left as they are.
// ---------------------------------------------------------------------------
// indexed_list_insert_remove_top
// Bounded ordered list held in a row of cells, with insert, remove, get, set
// and clear by rank.
// ---------------------------------------------------------------------------
module indexed_list_insert_remove_top import ilir_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  req_word_type        req_word,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rsp_word_type        rsp_word,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CNT_W-1:0]    csr_data
);

   // control state
   logic [CNT_W-1:0]   cap_ff, cap_in;
   logic [CNT_W-1:0]   fill_ff, fill_in;
   logic               s1_valid_ff, s1_valid_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // payload state
   logic [STAT_W-1:0]  s1_status_ff;
   logic [CNT_W-1:0]   s1_count_ff;
   logic               s1_rd_ff;
   rsp_word_type       rsp_word_ff;

   // decode results
   logic [CNT_W-1:0]   eff_cap;
   logic [STAT_W-1:0]  dec_status;
   cell_op_type        dec_op;
   logic               dec_rd;
   logic [CNT_W-1:0]   dec_fill;
   logic               has_entry;
   logic               pos_held;

   logic               s1_adv;
   logic               req_acc;
   cell_ctrl_type      cell_ctrl;
   logic [ELEM_W-1:0]  entry    [DEPTH];
   logic [ELEM_W-1:0]  sel_data [DEPTH];
   logic [ELEM_W-1:0]  gathered;

   // handshakes
   assign s1_adv    = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !s1_adv;
   assign req_acc   = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // command decode against the current count
   always_comb begin
      eff_cap    = (cap_ff > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : cap_ff;
      has_entry  = (fill_ff != '0);
      pos_held   = (req_word.position < fill_ff);
      dec_status = ST_OK;
      dec_op     = CELL_HOLD;
      dec_rd     = 1'b0;
      dec_fill   = fill_ff;
      case (req_word.cmd)
         CMD_INSERT: begin
            if (fill_ff >= eff_cap) begin
               dec_status = ST_FULL;
            end else if (req_word.position > fill_ff) begin
               dec_status = ST_BADPOS;
            end else begin
               dec_op   = CELL_INSERT;
               dec_fill = fill_ff + CNT_W'(1);
            end
         end
         CMD_REMOVE: begin
            if (!has_entry) begin
               dec_status = ST_EMPTY;
            end else if (!pos_held) begin
               dec_status = ST_BADPOS;
            end else begin
               dec_op   = CELL_REMOVE;
               dec_rd   = 1'b1;
               dec_fill = fill_ff - CNT_W'(1);
            end
         end
         CMD_GET: begin
            if (!has_entry) begin
               dec_status = ST_EMPTY;
            end else if (!pos_held) begin
               dec_status = ST_BADPOS;
            end else begin
               dec_rd = 1'b1;
            end
         end
         CMD_SET: begin
            if (!has_entry) begin
               dec_status = ST_EMPTY;
            end else if (!pos_held) begin
               dec_status = ST_BADPOS;
            end else begin
               dec_op = CELL_WRITE;
               dec_rd = 1'b1;
            end
         end
         CMD_CLEAR: begin
            dec_fill = '0;
         end
         default: begin
            dec_status = ST_OK;
         end
      endcase
   end

   // broadcast to the row
   assign cell_ctrl.op    = req_acc ? dec_op : CELL_HOLD;
   assign cell_ctrl.pos   = req_word.position;
   assign cell_ctrl.value = req_word.elem_value;

   // row of cells
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [ELEM_W-1:0] left_entry;
      logic [ELEM_W-1:0] right_entry;

      if (i == 0) begin : g_first
         assign left_entry = '0;
      end else begin : g_left
         assign left_entry = entry[i-1];
      end

      if (i == DEPTH-1) begin : g_last
         assign right_entry = '0;
      end else begin : g_right
         assign right_entry = entry[i+1];
      end

      ilir_cell u_cell (
         .clock       (clock),
         .ctrl        (cell_ctrl),
         .cell_idx    (CNT_W'(i)),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .entry       (entry[i]),
         .sel_data    (sel_data[i])
      );
   end

   // read tree, first level loaded with the old contents at accept
   ilir_gather u_gather (
      .clock    (clock),
      .load     (req_acc),
      .sel_data (sel_data),
      .data_out (gathered)
   );

   // next control state
   always_comb begin
      cap_in       = csr_valid ? csr_data : cap_ff;
      fill_in      = req_acc ? dec_fill : fill_ff;
      s1_valid_in  = req_acc || (s1_valid_ff && !s1_adv);
      rsp_valid_in = s1_adv || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= CNT_W'(CAP_RESET);
         fill_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cap_ff       <= cap_in;
         fill_ff      <= fill_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // stage and result payload
   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_status_ff <= dec_status;
         s1_count_ff  <= dec_fill;
         s1_rd_ff     <= dec_rd;
      end
      if (s1_adv) begin
         rsp_word_ff.status   <= s1_status_ff;
         rsp_word_ff.data_out <= s1_rd_ff ? gathered : '0;
         rsp_word_ff.count    <= s1_count_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

[rtl/core/ilir_checker.sv]
// ---------------------------------------------------------------------------
// ilir_checker
// Port-level checks on the indexed list, bound to the top level.
// ---------------------------------------------------------------------------
`include "indexed_list_insert_remove_top_defines.svh"

module ilir_checker import ilir_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  req_word_type        req_word,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  rsp_word_type        rsp_word
);

   // a stalled req word holds
   `ILIR_ASSERT_NEXT(a_req_hold, clock, reset, req_valid && req_stall, req_valid && $stable(req_word), "req word changed under stall")

   // a stalled result word holds
   `ILIR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_word), "rsp word changed under stall")

   // count never exceeds the built depth
   `ILIR_ASSERT_NOW(a_count_range, clock, reset, rsp_valid, rsp_word.count <= CNT_W'(DEPTH), "count above depth")

   // failed commands return no data
   `ILIR_ASSERT_NOW(a_fail_no_data, clock, reset, rsp_valid && (rsp_word.status != ST_OK), rsp_word.data_out == '0, "data on failed command")

   // an empty report always shows a zero count
   `ILIR_ASSERT_NOW(a_empty_count, clock, reset, rsp_valid && (rsp_word.status == ST_EMPTY), rsp_word.count == '0, "empty status with entries held")

endmodule

bind indexed_list_insert_remove_top ilir_checker u_ilir_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_word  (req_word),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);

[dv/tb_top.sv]
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the indexed list. A shadow copy of the list
// predicts status, data_out and count for every accepted req word. Result
// words are compared in order. Directed tests cover the empty list, edge
// ranks and capacity corners. Random traffic then runs at several capacity
// settings, with idle bursts on both sides, a long result hold-off and a
// final full-rate stretch.
// ---------------------------------------------------------------------------
module tb_top import ilir_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   // command codes the block ignores
   localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd5;
   localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

   localparam int CYCLE_LIMIT = 300000;
   localparam int HOLD_CYCLES = 80;
   localparam int RANK_MAX    = (1 << CNT_W) - 1;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   req_word_type      req_word  = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   rsp_word_type      rsp_word;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [CNT_W-1:0]  csr_data  = '0;

   // shadow list state
   bit [ELEM_W-1:0]   shadow_entries [DEPTH];
   int                shadow_count = 0;
   int                shadow_cap   = CAP_RESET;
   rsp_word_type      expected_rsp_q [$];

   int                fails      = 0;
   int                cycle_ctr  = 0;
   bit                req_idle_en = 1'b1;
   bit                rsp_idle_en = 1'b1;
   int                holds_asked = 0;
   int                holds_taken = 0;
   int                hold_left   = 0;
   int                burst_left  = 0;

   indexed_list_insert_remove_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_ctr++;
      if (cycle_ctr > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // shadow list: apply one command, return the result word it gives
   function automatic rsp_word_type apply_list_op(req_word_type w);
      rsp_word_type r;
      int           eff_cap;
      int           p;
      int           i;
      r       = '0;
      r.status = ST_OK;
      eff_cap = (shadow_cap > DEPTH) ? DEPTH : shadow_cap;
      p       = w.position;
      case (w.cmd)
         CMD_INSERT: begin
            if (shadow_count >= eff_cap)
               r.status = ST_FULL;
            else if (p > shadow_count)
               r.status = ST_BADPOS;
            else begin
               for (i = shadow_count; i > p; i--)
                  shadow_entries[i] = shadow_entries[i-1];
               shadow_entries[p] = w.elem_value;
               shadow_count++;
            end
         end
         CMD_REMOVE, CMD_GET, CMD_SET: begin
            if (shadow_count == 0)
               r.status = ST_EMPTY;
            else if (p >= shadow_count)
               r.status = ST_BADPOS;
            else begin
               r.data_out = shadow_entries[p];
               if (w.cmd == CMD_SET)
                  shadow_entries[p] = w.elem_value;
               else if (w.cmd == CMD_REMOVE) begin
                  for (i = p; i + 1 < shadow_count; i++)
                     shadow_entries[i] = shadow_entries[i+1];
                  shadow_count--;
               end
            end
         end
         CMD_CLEAR: shadow_count = 0;
         default: ;
      endcase
      r.count = CNT_W'(shadow_count);
      return r;
   endfunction

   // predict on each accepted req word, check each accepted rsp word
   always @(posedge clock) begin : list_scoreboard
      rsp_word_type want;
      if (!reset) begin
         if (csr_valid && csr_ready)
            shadow_cap = csr_data;
         if (req_valid && !req_stall)
            expected_rsp_q.push_back(apply_list_op(req_word));
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp_q.size() == 0) begin
               $error("rsp word with none expected: status %0d data_out %h count %0d",
                      rsp_word.status, rsp_word.data_out, rsp_word.count);
               fails++;
            end else begin
               want = expected_rsp_q.pop_front();
               if (rsp_word.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_word.status);
                  fails++;
               end
               if (rsp_word.data_out !== want.data_out) begin
                  $error("data_out: expected %h, got %h", want.data_out, rsp_word.data_out);
                  fails++;
               end
               if (rsp_word.count !== want.count) begin
                  $error("count: expected %0d, got %0d", want.count, rsp_word.count);
                  fails++;
               end
            end
         end
      end
   end

   // result side back-pressure: long hold-offs on request, else short bursts
   always @(posedge clock) begin
      if (holds_taken != holds_asked) begin
         holds_taken++;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (burst_left > 0) begin
         rsp_stall <= 1'b1;
         burst_left--;
      end else if (rsp_idle_en && $urandom_range(0, 99) < 15) begin
         rsp_stall <= 1'b1;
         burst_left = $urandom_range(0, 3);
      end else
         rsp_stall <= 1'b0;
   end

   // offer one req word, with an optional idle burst first
   task automatic send_op(input logic [CMD_W-1:0] op, input logic [CNT_W-1:0] rank,
                          input logic [ELEM_W-1:0] elem);
      if (req_idle_en && $urandom_range(0, 99) < 15) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_word.cmd        <= op;
      req_word.position   <= rank;
      req_word.elem_value <= elem;
      do @(posedge clock); while (req_stall);
   endtask

   // stop offering and wait until every expected word has come back
   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_rsp_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CNT_W-1:0] limit);
      csr_valid <= 1'b1;
      csr_data  <= limit;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // random command, biased towards ranks the list holds and away from overflow
   task automatic send_random_op();
      int                eff_cap;
      int                held;
      int                ins_w;
      int                roll;
      int                top;
      logic [CMD_W-1:0]  op;
      logic [CNT_W-1:0]  rank;
      logic [ELEM_W-1:0] elem;
      held    = shadow_count;
      eff_cap = (shadow_cap > DEPTH) ? DEPTH : shadow_cap;
      ins_w   = (held < eff_cap / 2 + 1) ? 45 : 30;
      roll    = $urandom_range(0, 99);
      if (roll < ins_w)
         op = CMD_INSERT;
      else if (roll < 70)
         op = CMD_REMOVE;
      else if (roll < 82)
         op = CMD_GET;
      else if (roll < 94)
         op = CMD_SET;
      else if (roll < 96)
         op = CMD_CLEAR;
      else
         op = CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
      top  = (op == CMD_INSERT) ? held : held - 1;
      roll = $urandom_range(0, 99);
      if (top < 0 || roll < 8)
         rank = CNT_W'($urandom_range(0, RANK_MAX));
      else if (roll < 18)
         rank = CNT_W'(top);
      else if (roll < 26)
         rank = '0;
      else
         rank = CNT_W'($urandom_range(0, top));
      roll = $urandom_range(0, 99);
      if (roll < 8)
         elem = '0;
      else if (roll < 16)
         elem = '1;
      else
         elem = $urandom;
      send_op(op, rank, elem);
   endtask

   // commands on an empty list, out-of-range ranks, ignored codes
   task automatic test_empty_list();
      send_op(CMD_REMOVE, '0, '0);
      send_op(CMD_GET, '0, '0);
      send_op(CMD_SET, '0, '1);
      send_op(CMD_INSERT, CNT_W'(1), $urandom);
      send_op(CMD_INSERT, CNT_W'(DEPTH), $urandom);
      send_op(CMD_UNUSED_LO, '0, '1);
      send_op(CMD_UNUSED_HI, '1, '1);
   endtask

   // insert at front, end and middle; read, replace, remove past the end and in the middle
   task automatic test_edge_ranks();
      send_op(CMD_INSERT, '0, '0);
      send_op(CMD_INSERT, CNT_W'(1), '1);
      send_op(CMD_INSERT, CNT_W'(1), 32'hA5A5_5A5A);
      send_op(CMD_GET, CNT_W'(2), '0);
      send_op(CMD_SET, CNT_W'(1), 32'h1234_5678);
      send_op(CMD_REMOVE, CNT_W'(3), '0);
      send_op(CMD_REMOVE, CNT_W'(1), '0);
      send_op(CMD_GET, '1, '0);
      send_op(CMD_CLEAR, '1, '1);
      send_op(CMD_GET, '0, '0);
   endtask

   // limit lowered under the count, zero limit, limit of one
   task automatic test_capacity_limits();
      int i;
      wait_for_results();
      write_capacity(CNT_W'(CAP_RESET));
      for (i = 0; i < 4; i++)
         send_op(CMD_INSERT, CNT_W'(i), $urandom);
      wait_for_results();
      write_capacity(CNT_W'(3));
      send_op(CMD_INSERT, '0, $urandom);
      send_op(CMD_REMOVE, CNT_W'(3), '0);
      send_op(CMD_REMOVE, '0, '0);
      send_op(CMD_INSERT, CNT_W'(2), $urandom);
      wait_for_results();
      write_capacity(CNT_W'(0));
      send_op(CMD_CLEAR, '0, '0);
      send_op(CMD_INSERT, '0, $urandom);
      wait_for_results();
      write_capacity(CNT_W'(1));
      send_op(CMD_INSERT, '0, $urandom);
      send_op(CMD_INSERT, '0, $urandom);
      send_op(CMD_SET, '0, $urandom);
   endtask

   // fill to full depth with a limit above it, overflow, then empty again
   task automatic test_fill_to_depth();
      int i;
      wait_for_results();
      write_capacity('1);
      send_op(CMD_CLEAR, '0, '0);
      for (i = 0; i < DEPTH; i++)
         send_op(CMD_INSERT, CNT_W'($urandom_range(0, i)), $urandom);
      send_op(CMD_INSERT, CNT_W'(DEPTH), $urandom);
      send_op(CMD_SET, CNT_W'(DEPTH - 1), $urandom);
      send_op(CMD_GET, CNT_W'(DEPTH), '0);
      for (i = DEPTH; i > 0; i--)
         send_op(CMD_REMOVE, CNT_W'($urandom_range(0, i - 1)), '0);
      send_op(CMD_REMOVE, '0, '0);
   endtask

   // random traffic under a spread of limits
   task automatic test_mixed_traffic();
      int limits [5];
      int k;
      limits = '{CAP_RESET, 2, 8, $urandom_range(1, DEPTH), 100};
      for (k = 0; k < 5; k++) begin
         wait_for_results();
         write_capacity(CNT_W'(limits[k]));
         repeat (220) send_random_op();
      end
   endtask

   // results held off while words keep coming, then a full pause on input
   task automatic test_output_hold_off();
      wait_for_results();
      write_capacity(CNT_W'(CAP_RESET));
      holds_asked++;
      repeat (120) send_random_op();
      wait_for_results();
      repeat (30) send_random_op();
   endtask

   // back-to-back words, no idling on either side
   task automatic test_full_rate();
      req_idle_en = 1'b0;
      rsp_idle_en = 1'b0;
      repeat (200) send_random_op();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_empty_list();
      test_edge_ranks();
      test_capacity_limits();
      test_fill_to_depth();
      test_mixed_traffic();
      test_output_hold_off();
      test_full_rate();
      wait_for_results();
      repeat (8) @(posedge clock);
      if (fails == 0 && expected_rsp_q.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/ilir_pkg.sv
rtl/core/ilir_cell.sv
rtl/core/ilir_gather.sv
rtl/core/indexed_list_insert_remove_top.sv
rtl/core/ilir_checker.sv
dv/tb_top.sv
